[hdl/cpu65_pkg.sv]
// ----------------------------------------------------------------------------
// cpu65_pkg
// Types, operation codes and flag helpers shared by the 6502 execute unit.
// ----------------------------------------------------------------------------
package cpu65_pkg;

    // Operation codes, mnemonics in alphabetical order.
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_AND = 6'd1;
    localparam logic [5:0] OP_ASL = 6'd2;
    localparam logic [5:0] OP_BCC = 6'd3;
    localparam logic [5:0] OP_BCS = 6'd4;
    localparam logic [5:0] OP_BEQ = 6'd5;
    localparam logic [5:0] OP_BIT = 6'd6;
    localparam logic [5:0] OP_BMI = 6'd7;
    localparam logic [5:0] OP_BNE = 6'd8;
    localparam logic [5:0] OP_BPL = 6'd9;
    localparam logic [5:0] OP_BRK = 6'd10;
    localparam logic [5:0] OP_BVC = 6'd11;
    localparam logic [5:0] OP_BVS = 6'd12;
    localparam logic [5:0] OP_CLC = 6'd13;
    localparam logic [5:0] OP_CLD = 6'd14;
    localparam logic [5:0] OP_CLI = 6'd15;
    localparam logic [5:0] OP_CLV = 6'd16;
    localparam logic [5:0] OP_CMP = 6'd17;
    localparam logic [5:0] OP_CPX = 6'd18;
    localparam logic [5:0] OP_CPY = 6'd19;
    localparam logic [5:0] OP_DEC = 6'd20;
    localparam logic [5:0] OP_DEX = 6'd21;
    localparam logic [5:0] OP_DEY = 6'd22;
    localparam logic [5:0] OP_EOR = 6'd23;
    localparam logic [5:0] OP_INC = 6'd24;
    localparam logic [5:0] OP_INX = 6'd25;
    localparam logic [5:0] OP_INY = 6'd26;
    localparam logic [5:0] OP_JMP = 6'd27;
    localparam logic [5:0] OP_JSR = 6'd28;
    localparam logic [5:0] OP_LDA = 6'd29;
    localparam logic [5:0] OP_LDX = 6'd30;
    localparam logic [5:0] OP_LDY = 6'd31;
    localparam logic [5:0] OP_LSR = 6'd32;
    localparam logic [5:0] OP_NOP = 6'd33;
    localparam logic [5:0] OP_ORA = 6'd34;
    localparam logic [5:0] OP_PHA = 6'd35;
    localparam logic [5:0] OP_PHP = 6'd36;
    localparam logic [5:0] OP_PLA = 6'd37;
    localparam logic [5:0] OP_PLP = 6'd38;
    localparam logic [5:0] OP_ROL = 6'd39;
    localparam logic [5:0] OP_ROR = 6'd40;
    localparam logic [5:0] OP_RTI = 6'd41;
    localparam logic [5:0] OP_RTS = 6'd42;
    localparam logic [5:0] OP_SBC = 6'd43;
    localparam logic [5:0] OP_SEC = 6'd44;
    localparam logic [5:0] OP_SED = 6'd45;
    localparam logic [5:0] OP_SEI = 6'd46;
    localparam logic [5:0] OP_STA = 6'd47;
    localparam logic [5:0] OP_STX = 6'd48;
    localparam logic [5:0] OP_STY = 6'd49;
    localparam logic [5:0] OP_TAX = 6'd50;
    localparam logic [5:0] OP_TAY = 6'd51;
    localparam logic [5:0] OP_TSX = 6'd52;
    localparam logic [5:0] OP_TXA = 6'd53;
    localparam logic [5:0] OP_TXS = 6'd54;
    localparam logic [5:0] OP_TYA = 6'd55;

    // Bit positions in the seven-bit flag register (N V B D I Z C).
    localparam int FB_C = 0;
    localparam int FB_Z = 1;
    localparam int FB_I = 2;
    localparam int FB_D = 3;
    localparam int FB_B = 4;
    localparam int FB_V = 5;
    localparam int FB_N = 6;

    localparam logic [6:0] FLAGS_RESET = 7'b0000100;
    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam int         STACK_DEPTH = 256;
    localparam int         STACK_WIDTH = 8;

    typedef logic [6:0] flags_t;

    typedef struct packed {
        logic [5:0]  operation;
        logic [7:0]  operand;
        logic        on_accumulator;
        logic [15:0] target_address;
        logic [15:0] fetched_pc;
    } in_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  acc_view;
        logic [7:0]  x_view;
        logic [7:0]  y_view;
        logic [7:0]  status_view;
        logic [7:0]  sp_view;
        logic [15:0] next_pc;
        logic [1:0]  extra_cycles;
    } out_word_t;

    // Architectural effect of one instruction, as seen by the ALU.
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        flags_t      flags;
        logic [15:0] npc;
        logic        we;
        logic [7:0]  wd;
        logic [1:0]  extra;
    } exec_t;

    // Status byte as read out: bit 5 always reads one.
    function automatic logic [7:0] status_byte(input flags_t f);
        status_byte = {f[FB_N], f[FB_V], 1'b1, f[FB_B], f[FB_D], f[FB_I], f[FB_Z], f[FB_C]};
    endfunction

    // Status byte as pushed by BRK and PHP: bits 5 and 4 set.
    function automatic logic [7:0] status_push(input flags_t f);
        status_push = {f[FB_N], f[FB_V], 1'b1, 1'b1, f[FB_D], f[FB_I], f[FB_Z], f[FB_C]};
    endfunction

    function automatic flags_t flags_from_byte(input logic [7:0] b);
        flags_from_byte = {b[7], b[6], b[4:0]};
    endfunction

    // Index of the final step of an operation; stack traffic takes one RAM
    // access per cycle while the unit is not stalled.
    function automatic logic [1:0] last_step(input logic [5:0] op);
        case (op)
            OP_BRK:  last_step = 2'd2;
            OP_JSR:  last_step = 2'd1;
            OP_RTI:  last_step = 2'd3;
            OP_RTS:  last_step = 2'd2;
            OP_PLA:  last_step = 2'd1;
            OP_PLP:  last_step = 2'd1;
            default: last_step = 2'd0;
        endcase
    endfunction

endpackage

[hdl/cpu65_ram.sv]
// ----------------------------------------------------------------------------
// cpu65_ram
// Generic single write port RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module cpu65_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cpu65_alu.sv]
// ----------------------------------------------------------------------------
// cpu65_alu
// Combinational execution of register, flag, branch and non-stack operations.
// ----------------------------------------------------------------------------
module cpu65_alu (
    input  logic [5:0]       op,
    input  logic [7:0]       m,
    input  logic             on_acc,
    input  logic [15:0]      tgt,
    input  logic [15:0]      pc,
    input  logic [7:0]       acc,
    input  logic [7:0]       x,
    input  logic [7:0]       y,
    input  logic [7:0]       sp,
    input  cpu65_pkg::flags_t flags,
    output cpu65_pkg::exec_t  res
);

    logic [8:0]  bin_add;
    logic [8:0]  bin_sub;
    logic [7:0]  nm;
    logic [5:0]  dlo;
    logic [4:0]  dhi0;
    logic [5:0]  dhi;
    logic [4:0]  slo;
    logic [4:0]  shi;
    logic [7:0]  sh_in;
    logic [7:0]  sh_out;
    logic        sh_c;
    logic [7:0]  cmp_r;
    logic [7:0]  diff;
    logic        take;
    logic [15:0] br_pc;
    logic        cin;

    assign cin = flags[cpu65_pkg::FB_C];
    assign nm  = ~m;
    assign bin_add = {1'b0, acc} + {1'b0, m} + {8'd0, cin};
    assign bin_sub = {1'b0, acc} + {1'b0, nm} + {8'd0, cin};
    assign br_pc = pc + {{8{m[7]}}, m};
    assign sh_in = on_acc ? acc : m;

    // Decimal adjust for addition.
    always_comb
    begin
        dlo = {2'b00, acc[3:0]} + {2'b00, m[3:0]} + {5'd0, cin};
        if (dlo > 6'd9)
        begin
            dlo = dlo + 6'd6;
        end
        dhi0 = {1'b0, acc[7:4]} + {1'b0, m[7:4]} + {4'd0, (dlo > 6'd15)};
        dhi  = {1'b0, dhi0};
        if (dhi > 6'd9)
        begin
            dhi = dhi + 6'd6;
        end
    end

    // Decimal adjust for subtraction, modulo 32 per nibble.
    always_comb
    begin
        slo = {1'b0, acc[3:0]} - {1'b0, m[3:0]} - {4'd0, ~cin};
        shi = {1'b0, acc[7:4]} - {1'b0, m[7:4]};
        if (slo[4])
        begin
            slo = slo - 5'd6;
            shi = shi - 5'd1;
        end
        if (shi[4])
        begin
            shi = shi - 5'd6;
        end
    end

    always_comb
    begin
        case (op)
            cpu65_pkg::OP_ASL:
            begin
                sh_c = sh_in[7];
                sh_out = {sh_in[6:0], 1'b0};
            end
            cpu65_pkg::OP_ROL:
            begin
                sh_c = sh_in[7];
                sh_out = {sh_in[6:0], cin};
            end
            cpu65_pkg::OP_ROR:
            begin
                sh_c = sh_in[0];
                sh_out = {cin, sh_in[7:1]};
            end
            default:
            begin
                sh_c = sh_in[0];
                sh_out = {1'b0, sh_in[7:1]};
            end
        endcase
    end

    always_comb
    begin
        case (op)
            cpu65_pkg::OP_CPX: cmp_r = x;
            cpu65_pkg::OP_CPY: cmp_r = y;
            default:           cmp_r = acc;
        endcase
        diff = cmp_r - m;
    end

    always_comb
    begin
        case (op)
            cpu65_pkg::OP_BCC: take = ~flags[cpu65_pkg::FB_C];
            cpu65_pkg::OP_BCS: take =  flags[cpu65_pkg::FB_C];
            cpu65_pkg::OP_BEQ: take =  flags[cpu65_pkg::FB_Z];
            cpu65_pkg::OP_BNE: take = ~flags[cpu65_pkg::FB_Z];
            cpu65_pkg::OP_BMI: take =  flags[cpu65_pkg::FB_N];
            cpu65_pkg::OP_BPL: take = ~flags[cpu65_pkg::FB_N];
            cpu65_pkg::OP_BVS: take =  flags[cpu65_pkg::FB_V];
            cpu65_pkg::OP_BVC: take = ~flags[cpu65_pkg::FB_V];
            default:           take = 1'b0;
        endcase
    end

    always_comb
    begin
        res.acc   = acc;
        res.x     = x;
        res.y     = y;
        res.sp    = sp;
        res.flags = flags;
        res.npc   = pc;
        res.we    = 1'b0;
        res.wd    = 8'd0;
        res.extra = 2'd0;
        case (op)
            cpu65_pkg::OP_ADC:
            begin
                if (flags[cpu65_pkg::FB_D])
                begin
                    res.flags[cpu65_pkg::FB_Z] = (bin_add[7:0] == 8'd0);
                    res.flags[cpu65_pkg::FB_N] = dhi0[3];
                    res.flags[cpu65_pkg::FB_V] = ~(acc[7] ^ m[7]) & (acc[7] ^ dhi0[3]);
                    res.flags[cpu65_pkg::FB_C] = (dhi > 6'd15);
                    res.acc = {dhi[3:0], dlo[3:0]};
                end
                else
                begin
                    res.flags[cpu65_pkg::FB_V] = ~(acc[7] ^ m[7]) & (acc[7] ^ bin_add[7]);
                    res.flags[cpu65_pkg::FB_C] = bin_add[8];
                    res.flags[cpu65_pkg::FB_N] = bin_add[7];
                    res.flags[cpu65_pkg::FB_Z] = (bin_add[7:0] == 8'd0);
                    res.acc = bin_add[7:0];
                end
            end
            cpu65_pkg::OP_SBC:
            begin
                res.flags[cpu65_pkg::FB_V] = ~(acc[7] ^ nm[7]) & (acc[7] ^ bin_sub[7]);
                res.flags[cpu65_pkg::FB_C] = bin_sub[8];
                res.flags[cpu65_pkg::FB_N] = bin_sub[7];
                res.flags[cpu65_pkg::FB_Z] = (bin_sub[7:0] == 8'd0);
                res.acc = flags[cpu65_pkg::FB_D] ? {shi[3:0], slo[3:0]} : bin_sub[7:0];
            end
            cpu65_pkg::OP_AND, cpu65_pkg::OP_ORA, cpu65_pkg::OP_EOR, cpu65_pkg::OP_LDA,
            cpu65_pkg::OP_TXA, cpu65_pkg::OP_TYA:
            begin
                case (op)
                    cpu65_pkg::OP_AND: res.acc = acc & m;
                    cpu65_pkg::OP_ORA: res.acc = acc | m;
                    cpu65_pkg::OP_EOR: res.acc = acc ^ m;
                    cpu65_pkg::OP_TXA: res.acc = x;
                    cpu65_pkg::OP_TYA: res.acc = y;
                    default:           res.acc = m;
                endcase
                res.flags[cpu65_pkg::FB_N] = res.acc[7];
                res.flags[cpu65_pkg::FB_Z] = (res.acc == 8'd0);
            end
            cpu65_pkg::OP_LDX, cpu65_pkg::OP_TAX, cpu65_pkg::OP_TSX, cpu65_pkg::OP_INX,
            cpu65_pkg::OP_DEX:
            begin
                case (op)
                    cpu65_pkg::OP_TAX: res.x = acc;
                    cpu65_pkg::OP_TSX: res.x = sp;
                    cpu65_pkg::OP_INX: res.x = x + 8'd1;
                    cpu65_pkg::OP_DEX: res.x = x - 8'd1;
                    default:           res.x = m;
                endcase
                res.flags[cpu65_pkg::FB_N] = res.x[7];
                res.flags[cpu65_pkg::FB_Z] = (res.x == 8'd0);
            end
            cpu65_pkg::OP_LDY, cpu65_pkg::OP_TAY, cpu65_pkg::OP_INY, cpu65_pkg::OP_DEY:
            begin
                case (op)
                    cpu65_pkg::OP_TAY: res.y = acc;
                    cpu65_pkg::OP_INY: res.y = y + 8'd1;
                    cpu65_pkg::OP_DEY: res.y = y - 8'd1;
                    default:           res.y = m;
                endcase
                res.flags[cpu65_pkg::FB_N] = res.y[7];
                res.flags[cpu65_pkg::FB_Z] = (res.y == 8'd0);
            end
            cpu65_pkg::OP_TXS: res.sp = x;
            cpu65_pkg::OP_BIT:
            begin
                res.flags[cpu65_pkg::FB_N] = m[7];
                res.flags[cpu65_pkg::FB_V] = m[6];
                res.flags[cpu65_pkg::FB_Z] = ((acc & m) == 8'd0);
            end
            cpu65_pkg::OP_CMP, cpu65_pkg::OP_CPX, cpu65_pkg::OP_CPY:
            begin
                res.flags[cpu65_pkg::FB_N] = diff[7];
                res.flags[cpu65_pkg::FB_Z] = (diff == 8'd0);
                res.flags[cpu65_pkg::FB_C] = (cmp_r >= m);
            end
            cpu65_pkg::OP_INC, cpu65_pkg::OP_DEC:
            begin
                res.wd = (op == cpu65_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                res.we = 1'b1;
                res.flags[cpu65_pkg::FB_N] = res.wd[7];
                res.flags[cpu65_pkg::FB_Z] = (res.wd == 8'd0);
            end
            cpu65_pkg::OP_ASL, cpu65_pkg::OP_LSR, cpu65_pkg::OP_ROL, cpu65_pkg::OP_ROR:
            begin
                res.flags[cpu65_pkg::FB_C] = sh_c;
                res.flags[cpu65_pkg::FB_N] = sh_out[7];
                res.flags[cpu65_pkg::FB_Z] = (sh_out == 8'd0);
                if (on_acc)
                begin
                    res.acc = sh_out;
                end
                else
                begin
                    res.we = 1'b1;
                    res.wd = sh_out;
                end
            end
            cpu65_pkg::OP_STA:
            begin
                res.we = 1'b1;
                res.wd = acc;
            end
            cpu65_pkg::OP_STX:
            begin
                res.we = 1'b1;
                res.wd = x;
            end
            cpu65_pkg::OP_STY:
            begin
                res.we = 1'b1;
                res.wd = y;
            end
            cpu65_pkg::OP_CLC: res.flags[cpu65_pkg::FB_C] = 1'b0;
            cpu65_pkg::OP_CLD: res.flags[cpu65_pkg::FB_D] = 1'b0;
            cpu65_pkg::OP_CLI: res.flags[cpu65_pkg::FB_I] = 1'b0;
            cpu65_pkg::OP_CLV: res.flags[cpu65_pkg::FB_V] = 1'b0;
            cpu65_pkg::OP_SEC: res.flags[cpu65_pkg::FB_C] = 1'b1;
            cpu65_pkg::OP_SED: res.flags[cpu65_pkg::FB_D] = 1'b1;
            cpu65_pkg::OP_SEI: res.flags[cpu65_pkg::FB_I] = 1'b1;
            cpu65_pkg::OP_JMP: res.npc = tgt;
            default:
            begin
                if (take)
                begin
                    res.npc = br_pc;
                    res.extra = (br_pc[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
                end
            end
        endcase
    end

endmodule

[hdl/cpu6502_execute_unit.sv]
// ----------------------------------------------------------------------------
// cpu6502_execute_unit
// Executes one decoded 6502 instruction per input word and returns its effect.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Word
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_ready, in_data    | decoded instruction
//   output  | out_valid, out_ready, out_data | write request, registers, PC
//
// An accepted word sits in the input register; its result is written to the
// output register when the instruction finishes and the output is free. For
// most instructions a new word is accepted every cycle while the output is
// not stalled. Stack instructions make at most one access to the stack page
// RAM per cycle while not stalled, and take no new word until their last
// step; a pull waits for the registered read of the RAM.
// Reset clears A, X and Y, sets SP to 0xFD and leaves only I set. The stack
// page is not cleared. A stalled output holds its word and also holds the
// instruction in the input register; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cpu65_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cpu65_pkg::out_word_t out_data
);

    // Input register.
    logic                in_valid_reg;
    cpu65_pkg::in_word_t in_reg;

    // Architectural state.
    logic [7:0]        acc_reg;
    logic [7:0]        x_reg;
    logic [7:0]        y_reg;
    logic [7:0]        sp_reg;
    cpu65_pkg::flags_t flags_reg;

    // Stack sequencing.
    logic [1:0] step_reg;
    logic [7:0] lo_reg;
    logic [7:0] lo_next;

    // Output register.
    logic                 out_valid_reg;
    cpu65_pkg::out_word_t out_reg;

    cpu65_pkg::exec_t alu_res;
    cpu65_pkg::exec_t nx;
    logic             out_free;
    logic             advance;
    logic             finish;
    logic [1:0]       last;
    logic             mem_we;
    logic [7:0]       mem_wd;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic [15:0]      jsr_ret;

    cpu65_alu u_alu (
        .op     (in_reg.operation),
        .m      (in_reg.operand),
        .on_acc (in_reg.on_accumulator),
        .tgt    (in_reg.target_address),
        .pc     (in_reg.fetched_pc),
        .acc    (acc_reg),
        .x      (x_reg),
        .y      (y_reg),
        .sp     (sp_reg),
        .flags  (flags_reg),
        .res    (alu_res)
    );

    // Pushes write at SP; pulls read at SP plus one, issued in the same cycle
    // as the increment.
    cpu65_ram #(
        .WIDTH (cpu65_pkg::STACK_WIDTH),
        .DEPTH (cpu65_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (sp_reg),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (sp_reg + 8'd1),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign last     = cpu65_pkg::last_step(in_reg.operation);
    assign finish   = advance && (step_reg == last);
    assign in_ready = !in_valid_reg || finish;
    assign jsr_ret  = in_reg.fetched_pc - 16'd1;

    // Next state for the current cycle: the ALU result, overridden by the
    // stack instructions one RAM access at a time.
    always_comb
    begin
        nx      = alu_res;
        mem_we  = 1'b0;
        mem_wd  = 8'd0;
        mem_re  = 1'b0;
        lo_next = lo_reg;
        case (in_reg.operation)
            cpu65_pkg::OP_BRK:
            begin
                mem_we = advance;
                case (step_reg)
                    2'd0:    mem_wd = in_reg.fetched_pc[15:8];
                    2'd1:    mem_wd = in_reg.fetched_pc[7:0];
                    default: mem_wd = cpu65_pkg::status_push(flags_reg);
                endcase
                nx.sp = sp_reg - 8'd1;
                nx.flags[cpu65_pkg::FB_B] = 1'b1;
                nx.npc = in_reg.target_address;
            end
            cpu65_pkg::OP_JSR:
            begin
                mem_we = advance;
                mem_wd = (step_reg == 2'd0) ? jsr_ret[15:8] : jsr_ret[7:0];
                nx.sp  = sp_reg - 8'd1;
                nx.npc = in_reg.target_address;
            end
            cpu65_pkg::OP_PHA:
            begin
                mem_we = advance;
                mem_wd = acc_reg;
                nx.sp  = sp_reg - 8'd1;
            end
            cpu65_pkg::OP_PHP:
            begin
                mem_we = advance;
                mem_wd = cpu65_pkg::status_push(flags_reg);
                nx.sp  = sp_reg - 8'd1;
            end
            cpu65_pkg::OP_PLA:
            begin
                if (step_reg == 2'd0)
                begin
                    mem_re = advance;
                    nx.sp  = sp_reg + 8'd1;
                end
                else
                begin
                    nx.acc = mem_rdata;
                    nx.flags[cpu65_pkg::FB_N] = mem_rdata[7];
                    nx.flags[cpu65_pkg::FB_Z] = (mem_rdata == 8'd0);
                end
            end
            cpu65_pkg::OP_PLP:
            begin
                if (step_reg == 2'd0)
                begin
                    mem_re = advance;
                    nx.sp  = sp_reg + 8'd1;
                end
                else
                begin
                    nx.flags = cpu65_pkg::flags_from_byte(mem_rdata);
                end
            end
            cpu65_pkg::OP_RTI:
            begin
                // Status, then PC low, then PC high.
                if (step_reg != 2'd3)
                begin
                    mem_re = advance;
                    nx.sp  = sp_reg + 8'd1;
                end
                if (step_reg == 2'd1)
                begin
                    nx.flags = cpu65_pkg::flags_from_byte(mem_rdata);
                end
                if (step_reg == 2'd2)
                begin
                    lo_next = mem_rdata;
                end
                nx.npc = {mem_rdata, lo_reg};
            end
            cpu65_pkg::OP_RTS:
            begin
                if (step_reg != 2'd2)
                begin
                    mem_re = advance;
                    nx.sp  = sp_reg + 8'd1;
                end
                if (step_reg == 2'd1)
                begin
                    lo_next = mem_rdata;
                end
                nx.npc = {mem_rdata, lo_reg} + 16'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            acc_reg       <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            sp_reg        <= cpu65_pkg::SP_RESET;
            flags_reg     <= cpu65_pkg::FLAGS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                acc_reg   <= nx.acc;
                x_reg     <= nx.x;
                y_reg     <= nx.y;
                sp_reg    <= nx.sp;
                flags_reg <= nx.flags;
                step_reg  <= finish ? 2'd0 : step_reg + 2'd1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            lo_reg <= lo_next;
        end
        if (finish)
        begin
            out_reg.write_enable  <= nx.we;
            out_reg.write_address <= nx.we ? in_reg.target_address : 16'd0;
            out_reg.write_data    <= nx.we ? nx.wd : 8'd0;
            out_reg.acc_view      <= nx.acc;
            out_reg.x_view        <= nx.x;
            out_reg.y_view        <= nx.y;
            out_reg.status_view   <= cpu65_pkg::status_byte(nx.flags);
            out_reg.sp_view       <= nx.sp;
            out_reg.next_pc       <= nx.npc;
            out_reg.extra_cycles  <= nx.extra;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[hdl/cpu65_checker.sv]
// ----------------------------------------------------------------------------
// cpu65_checker
// Port-level checks on the result words of the 6502 execute unit.
// ----------------------------------------------------------------------------
module cpu65_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input cpu65_pkg::out_word_t out_data
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Bit 5 of the status byte always reads one.
    a_status_bit5: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status_view[5])
        else $error("status bit 5 clear");

    // Without a write the address and data are zero.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |->
            out_data.write_address == 16'd0 && out_data.write_data == 8'd0)
        else $error("write fields set without write enable");

    // Only a taken branch adds cycles, and a branch never writes memory.
    a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.extra_cycles != 2'd0 |->
            !out_data.write_enable && out_data.extra_cycles != 2'd3)
        else $error("bad extra cycle count");

endmodule

bind cpu6502_execute_unit cpu65_checker u_cpu65_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
